// ===== sv/gpc_pkg.sv =====
// Shared types and constants for the grid path counter.
// No dependencies; used by gpc_row_ram, gpc_cell_unit and grid_path_count_mod_core.
package gpc_pkg;

    localparam int unsigned CountW = 30;
    localparam logic [CountW-1:0] PathMod = 30'd1000000007;

    localparam int unsigned RowsW = 16;
    localparam int unsigned ColsW = 11;
    localparam int unsigned CfgIdxW = 8;
    localparam int unsigned CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CFG_ROWS_IN_USE = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_COLS_IN_USE = 8'd1;

    typedef logic [CountW-1:0] t_count;

    typedef struct packed {
        logic blocked;
        logic first;
        logic top_row;
        logic left_col;
        logic last;
    } t_cell_ctrl;

endpackage

// ===== sv/gpc_row_ram.sv =====
// Row buffer: one write port, one read port, registered read data.
// Holds the previous row's counts; depends on gpc_pkg for the count type.
module gpc_row_ram #(
    parameter int unsigned Depth = 1024,
    parameter int unsigned AddrW = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [AddrW-1:0]     i_rd_addr,
    output gpc_pkg::t_count      o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AddrW-1:0]     i_wr_addr,
    input  gpc_pkg::t_count      i_wr_data
);

    gpc_pkg::t_count r_mem [Depth];
    gpc_pkg::t_count r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/gpc_cell_unit.sv =====
// Per-cell count: (above + left) mod P with start, edge and wall handling.
// Holds the left-neighbour count; depends on gpc_pkg.
module gpc_cell_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_commit,
    input  gpc_pkg::t_cell_ctrl  i_ctrl,
    input  gpc_pkg::t_count      i_above,
    output gpc_pkg::t_count      o_count
);

    gpc_pkg::t_count r_left;
    gpc_pkg::t_count w_above;
    gpc_pkg::t_count w_left;
    logic [gpc_pkg::CountW:0] w_sum;
    gpc_pkg::t_count w_count;

    always_comb begin
        w_above = (i_ctrl.top_row || (i_above >= gpc_pkg::PathMod)) ? '0 : i_above;
        w_left  = (i_ctrl.left_col || (r_left >= gpc_pkg::PathMod)) ? '0 : r_left;
        w_sum   = {1'b0, w_above} + {1'b0, w_left};
        if (w_sum >= {1'b0, gpc_pkg::PathMod}) begin
            w_sum = w_sum - {1'b0, gpc_pkg::PathMod};
        end
        if (i_ctrl.blocked) begin
            w_count = '0;
        end else if (i_ctrl.first) begin
            w_count = gpc_pkg::t_count'(1);
        end else begin
            w_count = w_sum[gpc_pkg::CountW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_left <= '0;
        end else if (i_commit) begin
            r_left <= w_count;
        end
    end

    assign o_count = w_count;

endmodule

// ===== sv/grid_path_count_mod_core.sv =====
// Grid path counter top level: index counters, row buffer pipeline, output word.
// Depends on gpc_pkg, gpc_row_ram and gpc_cell_unit.
//
//  channel  | direction | word contents
//  s (cell) | in        | tdata[0] cell_blocked
//  m (res)  | out       | tdata[29:0] path_count, tlast is_last
//  cfg      | in        | index 0 rows_in_use, 1 cols_in_use
//
// One cell a cycle while the output is not stalled; each word passes the stage-1 and
// output registers: the row buffer read registers at the accepting edge, the modular add
// and write-back run from the stage-1 registers as the output register loads.
// Back-to-back reads of the same column (one-column grids) take the forwarded count.
// A stall at the output holds the whole pipeline; reset needs no clearing pass.
module grid_path_count_mod_core #(
    parameter int unsigned MAX_COLS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,   // [0] cell_blocked
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [31:0]                    o_m_tdata,   // [29:0] path_count
    output logic                           o_m_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gpc_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [gpc_pkg::CfgDataW-1:0]   i_cfg_data
);

    localparam int unsigned AddrW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned CmpW  = 18;

    logic [gpc_pkg::RowsW-1:0] r_rows;
    logic [gpc_pkg::ColsW-1:0] r_cols;
    logic [AddrW-1:0]          r_col;
    logic [gpc_pkg::RowsW-1:0] r_row;

    logic                      r_s1_valid;
    logic [AddrW-1:0]          r_s1_col;
    gpc_pkg::t_cell_ctrl       r_s1_ctrl;
    logic                      r_fwd_hit;
    gpc_pkg::t_count           r_fwd_data;

    logic                      r_out_valid;
    gpc_pkg::t_count           r_out_count;
    logic                      r_out_last;

    logic                      w_adv;
    logic                      w_acc;
    logic                      w_cfg_wr;
    logic [gpc_pkg::RowsW-1:0] w_rows_m1;
    logic [AddrW-1:0]          w_cols_m1;
    logic                      w_col_end;
    logic                      w_row_end;
    gpc_pkg::t_cell_ctrl       w_ctrl;
    gpc_pkg::t_count           w_rd_data;
    gpc_pkg::t_count           w_above;
    gpc_pkg::t_count           w_count;

    assign w_adv       = !r_out_valid || i_m_tready;
    assign w_acc       = i_s_tvalid && w_adv;
    assign o_s_tready  = w_adv;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && ((i_cfg_index == gpc_pkg::CFG_ROWS_IN_USE) ||
                                         (i_cfg_index == gpc_pkg::CFG_COLS_IN_USE));

    always_comb begin
        w_rows_m1 = (r_rows == '0) ? '0 : r_rows - gpc_pkg::RowsW'(1);
        if (r_cols == '0) begin
            w_cols_m1 = '0;
        end else if (CmpW'(r_cols) > CmpW'(MAX_COLS)) begin
            w_cols_m1 = AddrW'(MAX_COLS - 1);
        end else begin
            w_cols_m1 = AddrW'(r_cols - gpc_pkg::ColsW'(1));
        end
        w_col_end       = (r_col == w_cols_m1);
        w_row_end       = (r_row == w_rows_m1);
        w_ctrl.blocked  = i_s_tdata[0];
        w_ctrl.top_row  = (r_row == '0);
        w_ctrl.left_col = (r_col == '0);
        w_ctrl.first    = w_ctrl.top_row && w_ctrl.left_col;
        w_ctrl.last     = w_col_end && w_row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= gpc_pkg::RowsW'(1);
            r_cols <= gpc_pkg::ColsW'(1);
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                gpc_pkg::CFG_ROWS_IN_USE: begin
                    r_rows <= i_cfg_data;
                    r_col  <= '0;
                    r_row  <= '0;
                end
                gpc_pkg::CFG_COLS_IN_USE: begin
                    r_cols <= i_cfg_data[gpc_pkg::ColsW-1:0];
                    r_col  <= '0;
                    r_row  <= '0;
                end
                default: begin
                end
            endcase
        end else if (w_acc) begin
            if (w_col_end) begin
                r_col <= '0;
                r_row <= w_row_end ? '0 : r_row + gpc_pkg::RowsW'(1);
            end else begin
                r_col <= r_col + AddrW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= w_acc;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_col    <= r_col;
            r_s1_ctrl   <= w_ctrl;
            r_fwd_hit   <= r_s1_valid && (r_s1_col == r_col);
            r_fwd_data  <= w_count;
            r_out_count <= w_count;
            r_out_last  <= r_s1_ctrl.last;
        end
    end

    gpc_row_ram #(
        .Depth (MAX_COLS),
        .AddrW (AddrW)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_acc),
        .i_rd_addr (r_col),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_adv && r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (w_count)
    );

    assign w_above = r_fwd_hit ? r_fwd_data : w_rd_data;

    gpc_cell_unit u_cell_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_cfg_wr),
        .i_commit (w_adv && r_s1_valid),
        .i_ctrl   (r_s1_ctrl),
        .i_above  (w_above),
        .o_count  (w_count)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_count};
    assign o_m_tlast  = r_out_last;

endmodule

// ===== test/tb_grid_path_count_mod_core.sv =====
// Self-checking testbench for grid_path_count_mod_core: streams grid cells, predicts each
// cell's path count mod 1000000007 and the last-cell flag, and compares every output word.
// Depends on gpc_pkg and the grid_path_count_mod_core RTL.
module tb_grid_path_count_mod_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MaxCols = 1024;
    localparam int unsigned RandomCells = 1850;

    typedef struct packed {
        gpc_pkg::t_count path_count;
        logic            is_last;
    } t_path_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_s_tvalid = 1'b0;
    logic                         o_s_tready;
    logic [7:0]                   i_s_tdata = '0;     // [0] cell_blocked
    logic                         o_m_tvalid;
    logic                         i_m_tready = 1'b0;
    logic [31:0]                  o_m_tdata;          // [29:0] path_count
    logic                         o_m_tlast;          // is_last
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [gpc_pkg::CfgIdxW-1:0]  i_cfg_index = '0;
    logic [gpc_pkg::CfgDataW-1:0] i_cfg_data = '0;

    // path count model
    logic [gpc_pkg::RowsW-1:0] grid_rows = 16'd1;
    logic [gpc_pkg::ColsW-1:0] grid_cols = 11'd1;
    gpc_pkg::t_count           prev_row_count [MaxCols];
    gpc_pkg::t_count           left_path;
    int unsigned               cur_col;
    int unsigned               cur_row;

    logic             cells_to_send [$];
    t_path_result     predicted_paths [$];
    logic             cell_taken = 1'b0;
    logic             cfg_taken = 1'b0;
    logic             sender_idles = 1'b1;
    logic             receiver_idles = 1'b1;
    int unsigned      gap_left = 0;
    int unsigned      stall_left = 0;
    int unsigned      cells_queued = 0;
    int unsigned      cfg_writes = 0;
    int unsigned      grids_done = 0;
    int unsigned      mismatches = 0;

    grid_path_count_mod_core #(
        .MAX_COLS(MaxCols)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    task automatic clear_model();
        grid_rows = 16'd1;
        grid_cols = 11'd1;
        for (int i = 0; i < MaxCols; i++) prev_row_count[i] = '0;
        left_path = '0;
        cur_col = 0;
        cur_row = 0;
    endtask

    task automatic count_cell(input logic blocked, output t_path_result res);
        int unsigned rows_eff;
        int unsigned cols_eff;
        int unsigned col;
        int unsigned row;
        logic [31:0] above;
        logic [31:0] from_left;
        logic [31:0] total;
        rows_eff = (grid_rows == 0) ? 1 : grid_rows;
        cols_eff = (grid_cols == 0) ? 1 : ((grid_cols > MaxCols) ? MaxCols : grid_cols);
        col = (cur_col >= cols_eff) ? 0 : cur_col;
        row = (cur_row >= rows_eff) ? 0 : cur_row;
        if (blocked) begin
            total = 0;
        end else if (row == 0 && col == 0) begin
            total = 1;
        end else begin
            above = (row == 0) ? 0 : 32'(prev_row_count[col]);
            from_left = (col == 0) ? 0 : 32'(left_path);
            if (above >= gpc_pkg::PathMod) above = 0;
            if (from_left >= gpc_pkg::PathMod) from_left = 0;
            total = above + from_left;
            if (total >= gpc_pkg::PathMod) total = total - gpc_pkg::PathMod;
        end
        prev_row_count[col] = total[gpc_pkg::CountW-1:0];
        left_path = total[gpc_pkg::CountW-1:0];
        res.path_count = total[gpc_pkg::CountW-1:0];
        res.is_last = (row == rows_eff - 1) && (col == cols_eff - 1);
        if (col + 1 >= cols_eff) begin
            cur_col = 0;
            cur_row = (row + 1 >= rows_eff) ? 0 : row + 1;
        end else begin
            cur_col = col + 1;
            cur_row = row;
        end
    endtask

    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 6);
    endfunction

    function automatic int unsigned pick_block_pct();
        case ($urandom_range(5))
            0, 1: return 0;
            2: return 5;
            3: return 15;
            4: return 40;
            default: return $urandom_range(100, 60);
        endcase
    endfunction

    function automatic logic [15:0] pick_side();
        int unsigned r;
        r = $urandom_range(19);
        if (r == 0) return 16'd0;
        if (r < 3) return 16'($urandom_range(22, 16));
        return 16'($urandom_range(10, 1));
    endfunction

    task automatic queue_cells(input int unsigned n, input int unsigned block_pct);
        repeat (n) begin
            cells_to_send.push_back($urandom_range(99) < block_pct);
            cells_queued++;
        end
    endtask

    task automatic queue_bits(input logic [15:0] pattern, input int unsigned n);
        for (int i = 0; i < n; i++) begin
            cells_to_send.push_back(pattern[i]);
            cells_queued++;
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (cells_to_send.size() != 0 || i_s_tvalid || predicted_paths.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [gpc_pkg::CfgIdxW-1:0] idx,
                             input logic [gpc_pkg::CfgDataW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(negedge i_clk);
        while (!cfg_taken);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // cell driver
    always @(negedge i_clk) begin
        if (!i_s_tvalid || cell_taken) begin
            if (gap_left != 0) begin
                i_s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cells_to_send.size() != 0) begin
                i_s_tdata <= {7'd0, cells_to_send.pop_front()};
                i_s_tvalid <= 1'b1;
                gap_left <= sender_idles ? pause_len() : 0;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (!receiver_idles) begin
            i_m_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < 25) begin
            i_m_tready <= 1'b0;
            stall_left <= pause_len();
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_path_result want;
        cell_taken <= i_s_tvalid && o_s_tready;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_cfg_valid && o_cfg_ready &&
                (i_cfg_index == gpc_pkg::CFG_ROWS_IN_USE ||
                 i_cfg_index == gpc_pkg::CFG_COLS_IN_USE)) begin
                if (i_cfg_index == gpc_pkg::CFG_ROWS_IN_USE) grid_rows = i_cfg_data;
                else grid_cols = i_cfg_data[gpc_pkg::ColsW-1:0];
                cur_col = 0;
                cur_row = 0;
                left_path = '0;
            end
            if (i_s_tvalid && o_s_tready) begin
                count_cell(i_s_tdata[0], want);
                predicted_paths.push_back(want);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (predicted_paths.size() == 0) begin
                    $error("unexpected word: path_count %0d, is_last %0b",
                           o_m_tdata[gpc_pkg::CountW-1:0], o_m_tlast);
                    mismatches++;
                end else begin
                    want = predicted_paths.pop_front();
                    if (o_m_tdata[gpc_pkg::CountW-1:0] !== want.path_count) begin
                        $error("path_count: expected %0d, got %0d",
                               want.path_count, o_m_tdata[gpc_pkg::CountW-1:0]);
                        mismatches++;
                    end
                    if (o_m_tlast !== want.is_last) begin
                        $error("is_last: expected %0b, got %0b", want.is_last, o_m_tlast);
                        mismatches++;
                    end
                    if (want.is_last) grids_done++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [15:0] rows_cfg;
        logic [15:0] cols_cfg;
        int unsigned grid_cells;
        int unsigned shape;
        int unsigned directed_cells;
        bit          wide_done;
        wide_done = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one-cell grid from reset values, open then blocked
        queue_bits(16'b10, 2);
        wait_idle();
        write_reg(gpc_pkg::CFG_ROWS_IN_USE, 16'd0);
        write_reg(gpc_pkg::CFG_COLS_IN_USE, 16'd0);
        queue_bits(16'b0, 1);
        wait_idle();
        write_reg(gpc_pkg::CFG_ROWS_IN_USE, 16'd3);
        write_reg(gpc_pkg::CFG_COLS_IN_USE, 16'd3);
        queue_bits(16'b000010000, 9);
        wait_idle();
        // blocked start, unknown register index mid-grid, blocked destination
        write_reg(gpc_pkg::CFG_ROWS_IN_USE, 16'd2);
        write_reg(gpc_pkg::CFG_COLS_IN_USE, 16'd2);
        queue_bits(16'b01, 2);
        wait_idle();
        write_reg(8'd7, 16'hFFFF);
        queue_bits(16'b10, 2);
        wait_idle();
        write_reg(gpc_pkg::CFG_COLS_IN_USE, 16'hF801);
        write_reg(gpc_pkg::CFG_ROWS_IN_USE, 16'hFFFF);
        queue_bits(16'b0100, 4);
        directed_cells = cells_queued;

        while (cells_queued < directed_cells + RandomCells) begin
            wait_idle();
            sender_idles = ($urandom_range(3) != 0);
            receiver_idles = ($urandom_range(3) != 0);
            shape = $urandom_range(99);
            if (!wide_done && cells_queued > 700) begin
                write_reg(gpc_pkg::CFG_ROWS_IN_USE, 16'd1);
                write_reg(gpc_pkg::CFG_COLS_IN_USE, 16'hFFFF);
                queue_cells(MaxCols, $urandom_range(1));
                wide_done = 1'b1;
            end else if (shape < 12) begin
                rows_cfg = ($urandom_range(1) != 0) ? 16'hFFFF : 16'($urandom_range(80, 2));
                write_reg(gpc_pkg::CFG_COLS_IN_USE, {5'($urandom), 11'd1});
                write_reg(gpc_pkg::CFG_ROWS_IN_USE, rows_cfg);
                queue_cells($urandom_range(60, 10), pick_block_pct());
            end else begin
                rows_cfg = pick_side();
                cols_cfg = pick_side();
                if ($urandom_range(1) != 0) begin
                    write_reg(gpc_pkg::CFG_ROWS_IN_USE, rows_cfg);
                    write_reg(gpc_pkg::CFG_COLS_IN_USE, {5'($urandom), cols_cfg[10:0]});
                end else begin
                    write_reg(gpc_pkg::CFG_COLS_IN_USE, {5'($urandom), cols_cfg[10:0]});
                    write_reg(gpc_pkg::CFG_ROWS_IN_USE, rows_cfg);
                end
                grid_cells = ((rows_cfg == 0) ? 1 : rows_cfg) * ((cols_cfg == 0) ? 1 : cols_cfg);
                repeat ($urandom_range(3, 1)) queue_cells(grid_cells, pick_block_pct());
                if ($urandom_range(4) == 0) begin
                    // break off mid-grid, poke an unused index, carry on
                    queue_cells($urandom_range(grid_cells), pick_block_pct());
                    wait_idle();
                    write_reg(8'($urandom_range(255, 2)), 16'($urandom));
                    queue_cells(grid_cells, pick_block_pct());
                end
            end
        end

        wait_idle();
        repeat (20) @(negedge i_clk);
        $display("Streamed %0d cells over %0d finished grids with %0d register writes,",
                 cells_queued, grids_done, cfg_writes);
        $display("shapes from 1x1 to 65535x1 and 1x1024, with stalls on both sides.");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
